// ----- src/stop_and_wait_arq_relay_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stop-and-wait ARQ relay core
// Concurrent property wrappers, clocked on the rising edge and disabled
// during reset.
// ----------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_ARQ_RELAY_CORE_ASSERT_SVH
`define STOP_AND_WAIT_ARQ_RELAY_CORE_ASSERT_SVH

// same-cycle implication
`define SWARQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("relay core assertion failed");

// next-cycle implication
`define SWARQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("relay core assertion failed");

`endif

// ----- src/swarq_pkg.sv -----
// ----------------------------------------------------------------------------
// swarq_pkg
// Codes and types shared by the stop-and-wait ARQ relay core.
// ----------------------------------------------------------------------------
`default_nettype none

package swarq_pkg;

	// routing threshold register
	localparam int THR_W = 17;
	localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

	// input item kinds
	typedef enum logic [1:0] {
		IN_SRC  = 2'd0,
		IN_DATA = 2'd1,
		IN_ACK  = 2'd2,
		IN_NAK  = 2'd3
	} in_kind_t;

	// result item kinds
	typedef enum logic [1:0] {
		OUT_DATA = 2'd0,
		OUT_ACK  = 2'd1,
		OUT_NAK  = 2'd2
	} out_kind_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BUSY      = 2'd1,
		ST_ACK_EMPTY = 2'd2,
		ST_DROP      = 2'd3
	} status_t;

	// one result slot; tag travels separately
	typedef struct packed {
		out_kind_t kind;
		logic      port;
		status_t   status;
		logic      send;
		logic      mem_tag;   // tag comes from the retransmit store read
	} res_t;

endpackage

`default_nettype wire

// ----- src/stop_and_wait_arq_relay_core.sv -----
// ----------------------------------------------------------------------------
// stop_and_wait_arq_relay_core
// Two-port stop-and-wait ARQ relay with per-port retransmit queues.
// ----------------------------------------------------------------------------
// An input item is registered, decided combinationally (routing, queue update,
// ACK/NAK answer) and moved into the result register, from which its zero,
// one or two result items leave over the single output channel, one per
// cycle while out_ready is high. An item with results waits for the result
// register to drain; two results are an ACK plus a forwarded or dropped data
// packet. An item with no result (a packet queued behind others, a NAK on an
// empty queue, an ACK that empties its queue) shows nothing. The output
// channel sets the rate. Each port holds a queue of QUEUE_DEPTH tags in a
// shared store with a registered read port; a push onto a full queue is
// dropped and reported. The store needs no initialization: only entries that
// were pushed are ever read. The routing threshold register thr_q is written
// through the cfg channel, which is always ready.
`default_nettype none

module stop_and_wait_arq_relay_core #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_WIDTH   = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration write
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [swarq_pkg::THR_W-1:0] cfg_data,
	// input items
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                kind,
	input  wire logic                      arrival_port,
	input  wire logic                      bit_error,
	input  wire logic [15:0]               packet_tag,
	input  wire logic [15:0]               random_sample,
	input  wire logic                      busy_port_zero,
	input  wire logic                      busy_port_one,
	// result items
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [1:0]                     out_kind,
	output logic                           out_port,
	output logic [15:0]                    out_tag,
	output logic [1:0]                     status,
	output logic                           send_valid,
	output logic                           last
);

`include "stop_and_wait_arq_relay_core_assert.svh"

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = IW + 1;
	localparam int MEM_DEPTH = 2 * (1 << IW);
	localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
	localparam logic [FW-1:0] FULL_CNT = FW'(QUEUE_DEPTH);
	localparam logic [FW-1:0] ONE_CNT  = FW'(1);

	// configuration register
	logic [swarq_pkg::THR_W-1:0] thr_q;

	// queue pointers, one lane per port
	logic [1:0][IW-1:0] head_q;
	logic [1:0][IW-1:0] tail_q;
	logic [1:0][FW-1:0] fill_q;

	// retransmit store and its read register
	logic [TAG_WIDTH-1:0] store_q [MEM_DEPTH];
	logic [TAG_WIDTH-1:0] mem_rd_q;

	// input register
	logic                  valid_s1;
	swarq_pkg::in_kind_t   kind_s1;
	logic                  port_s1;
	logic                  err_s1;
	logic [15:0]           tag_s1;
	logic [15:0]           sample_s1;
	logic                  busy0_s1;
	logic                  busy1_s1;

	// result register
	logic                  valid_s2;
	logic                  two_s2;
	logic                  idx_q;
	swarq_pkg::res_t       slot0_s2;
	swarq_pkg::res_t       slot1_s2;
	logic [TAG_WIDTH-1:0]  tag0_s2;
	logic [TAG_WIDTH-1:0]  tag1_s2;

	// decision logic signals
	logic                  route_p;
	logic                  act_port;
	logic [IW-1:0]         act_head;
	logic [IW-1:0]         act_tail;
	logic [FW-1:0]         act_fill;
	logic [IW-1:0]         next_head;
	logic [IW-1:0]         next_tail;
	logic                  act_busy;
	logic                  act_full;
	logic                  act_empty;
	logic [TAG_WIDTH+15:0] in_tag_ext;
	logic [TAG_WIDTH-1:0]  in_tag;
	logic                  rt_push;
	logic                  rt_emit;
	swarq_pkg::res_t       rt_res;
	swarq_pkg::res_t       hd_res;

	logic                  any_n;
	logic                  two_n;
	swarq_pkg::res_t       slot0_n;
	swarq_pkg::res_t       slot1_n;
	logic [TAG_WIDTH-1:0]  tag0_n;
	logic [TAG_WIDTH-1:0]  tag1_n;
	logic                  push;
	logic                  pop;
	logic                  rd_en;
	logic [IW-1:0]         rd_idx;

	// handshake signals
	logic                  out_fire;
	logic                  s2_free;
	logic                  s1_go;
	logic                  load_s2;
	swarq_pkg::res_t       sel_res;
	logic [TAG_WIDTH-1:0]  sel_tag;
	logic [TAG_WIDTH+15:0] out_tag_ext;

	// routing and queue view of the port this item acts on
	assign route_p   = ({1'b0, sample_s1} < thr_q) ? 1'b0 : 1'b1;
	assign act_port  = (kind_s1 == swarq_pkg::IN_SRC || kind_s1 == swarq_pkg::IN_DATA)
		? route_p : port_s1;
	assign act_head  = head_q[act_port];
	assign act_tail  = tail_q[act_port];
	assign act_fill  = fill_q[act_port];
	assign next_head = (act_head == LAST_IDX) ? '0 : act_head + IW'(1);
	assign next_tail = (act_tail == LAST_IDX) ? '0 : act_tail + IW'(1);
	assign act_busy  = act_port ? busy1_s1 : busy0_s1;
	assign act_full  = (act_fill == FULL_CNT);
	assign act_empty = (act_fill == '0);

	assign in_tag_ext = {{TAG_WIDTH{1'b0}}, tag_s1};
	assign in_tag     = in_tag_ext[TAG_WIDTH-1:0];

	// result for a new packet routed to a queue
	always_comb begin
		rt_push = 1'b0;
		rt_emit = 1'b0;
		rt_res  = '{kind: swarq_pkg::OUT_DATA, port: act_port, status: swarq_pkg::ST_DROP,
			send: 1'b0, mem_tag: 1'b0};
		if (act_full) begin
			rt_emit = 1'b1;
		end else begin
			rt_push = 1'b1;
			rt_emit = act_empty;
			rt_res.status = act_busy ? swarq_pkg::ST_BUSY : swarq_pkg::ST_OK;
			rt_res.send   = !act_busy;
		end
	end

	// data send of the queue head, tag from the store
	assign hd_res = '{kind: swarq_pkg::OUT_DATA, port: act_port,
		status: act_busy ? swarq_pkg::ST_BUSY : swarq_pkg::ST_OK,
		send: !act_busy, mem_tag: 1'b1};

	// per-kind decision
	always_comb begin
		any_n   = 1'b0;
		two_n   = 1'b0;
		slot0_n = '0;
		slot1_n = '0;
		tag0_n  = '0;
		tag1_n  = '0;
		push    = 1'b0;
		pop     = 1'b0;
		rd_en   = 1'b0;
		rd_idx  = act_head;
		unique case (kind_s1)
			swarq_pkg::IN_SRC: begin
				push    = rt_push;
				any_n   = rt_emit;
				slot0_n = rt_res;
				tag0_n  = in_tag;
			end
			swarq_pkg::IN_DATA: begin
				any_n = 1'b1;
				if (err_s1) begin
					slot0_n = '{kind: swarq_pkg::OUT_NAK, port: port_s1,
						status: swarq_pkg::ST_OK, send: 1'b1, mem_tag: 1'b0};
				end else begin
					slot0_n = '{kind: swarq_pkg::OUT_ACK, port: port_s1,
						status: swarq_pkg::ST_OK, send: 1'b1, mem_tag: 1'b0};
					push    = rt_push;
					two_n   = rt_emit;
					slot1_n = rt_res;
					tag1_n  = in_tag;
				end
			end
			swarq_pkg::IN_ACK: begin
				if (act_empty) begin
					any_n   = 1'b1;
					slot0_n = '{kind: swarq_pkg::OUT_ACK, port: port_s1,
						status: swarq_pkg::ST_ACK_EMPTY, send: 1'b0, mem_tag: 1'b0};
				end else begin
					pop = 1'b1;
					if (act_fill != ONE_CNT) begin
						any_n   = 1'b1;
						slot0_n = hd_res;
						rd_en   = 1'b1;
						rd_idx  = next_head;
					end
				end
			end
			swarq_pkg::IN_NAK: begin
				if (!act_empty) begin
					any_n   = 1'b1;
					slot0_n = hd_res;
					rd_en   = 1'b1;
				end
			end
			default: begin
				any_n = 1'b0;
			end
		endcase
	end

	// flow control
	assign out_valid = valid_s2;
	assign last      = !two_s2 || idx_q;
	assign out_fire  = out_valid && out_ready;
	assign s2_free   = !valid_s2 || (out_fire && last);
	assign s1_go     = valid_s1 && (!any_n || s2_free);
	assign load_s2   = s1_go && any_n;
	assign in_ready  = !valid_s1 || s1_go;
	assign cfg_ready = 1'b1;

	// output selection
	assign sel_res     = idx_q ? slot1_s2 : slot0_s2;
	assign sel_tag     = sel_res.mem_tag ? mem_rd_q : (idx_q ? tag1_s2 : tag0_s2);
	assign out_tag_ext = {16'b0, sel_tag};
	assign out_kind    = sel_res.kind;
	assign out_port    = sel_res.port;
	assign status      = sel_res.status;
	assign send_valid  = sel_res.send;
	assign out_tag     = out_tag_ext[15:0];

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= swarq_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1   <= swarq_pkg::in_kind_t'(kind);
			port_s1   <= arrival_port;
			err_s1    <= bit_error;
			tag_s1    <= packet_tag;
			sample_s1 <= random_sample;
			busy0_s1  <= busy_port_zero;
			busy1_s1  <= busy_port_one;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else if (s1_go) begin
			if (push) begin
				tail_q[act_port] <= next_tail;
				fill_q[act_port] <= act_fill + ONE_CNT;
			end
			if (pop) begin
				head_q[act_port] <= next_head;
				fill_q[act_port] <= act_fill - ONE_CNT;
			end
		end
	end

	// retransmit store: one write, one registered read
	always_ff @(posedge clk) begin
		if (s1_go && push) begin
			store_q[AW'({act_port, act_tail})] <= in_tag;
		end
		if (load_s2 && rd_en) begin
			mem_rd_q <= store_q[AW'({act_port, rd_idx})];
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			two_s2   <= 1'b0;
			idx_q    <= 1'b0;
		end else begin
			if (load_s2) begin
				valid_s2 <= 1'b1;
				two_s2   <= two_n;
				idx_q    <= 1'b0;
			end else if (out_fire) begin
				if (last) begin
					valid_s2 <= 1'b0;
					idx_q    <= 1'b0;
				end else begin
					idx_q <= 1'b1;
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_s2) begin
			slot0_s2 <= slot0_n;
			slot1_s2 <= slot1_n;
			tag0_s2  <= tag0_n;
			tag1_s2  <= tag1_n;
		end
	end

	// checks
	`SWARQ_ASSERT_NEXT(a_second_follows, clk, arst_n, out_fire && !last, out_valid && last)
	`SWARQ_ASSERT_IMPLY(a_no_push_full, clk, arst_n, s1_go && push, act_fill != FULL_CNT)
	`SWARQ_ASSERT_IMPLY(a_send_is_ok, clk, arst_n, out_valid && send_valid,
		status == swarq_pkg::ST_OK)
	`SWARQ_ASSERT_IMPLY(a_no_pop_empty, clk, arst_n, s1_go && pop, act_fill != '0)

endmodule

`default_nettype wire
